// ===== design/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the filtered threshold switch.
// ----------------------------------------------------------------------------
package fts_pkg;

   localparam int DATA_W         = 16;   // sample, level and threshold width
   localparam int LEN_W          = 5;    // window length register width
   localparam int MODE_W         = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int MAX_WINDOW_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_MODE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD   = 3'd5;

   // event modes
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HYST   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;    // take the item's sample
      logic mem_read;   // advance position, read oldest entry
      logic update;     // update sum and store, load divider
      logic div_step;   // one quotient bit
      logic finish;     // compare and load the result register
   } cmd_type;

   typedef struct packed {
      logic filter_en;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

// ===== design/fts_ram.sv =====
// ----------------------------------------------------------------------------
// fts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fts_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fts_ctrl.sv =====
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer: capture, window read, update, serial divide, result load; filter off goes from capture to result load.
// ----------------------------------------------------------------------------
module fts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output fts_pkg::cmd_type cmd,
   input  fts_pkg::sts_type sts
);

   fts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.filter_en ? fts_pkg::ST_READ : fts_pkg::ST_FINISH;
            end
         end
         fts_pkg::ST_READ:   state_in = fts_pkg::ST_UPDATE;
         fts_pkg::ST_UPDATE: state_in = fts_pkg::ST_DIVIDE;
         fts_pkg::ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = fts_pkg::ST_FINISH;
            end
         end
         fts_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = fts_pkg::ST_IDLE;
            end
         end
         default: state_in = fts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         fts_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         fts_pkg::ST_READ:   cmd.mem_read = 1'b1;
         fts_pkg::ST_UPDATE: cmd.update   = 1'b1;
         fts_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         fts_pkg::ST_FINISH: cmd.finish   = sts.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/fts_dp.sv =====
// ----------------------------------------------------------------------------
// fts_dp
// Datapath: config registers, window store, running sum, serial divider,
// threshold logic and result register.
// ----------------------------------------------------------------------------
module fts_dp #(
   parameter int MAX_WINDOW = fts_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [fts_pkg::DATA_W-1:0]       req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fts_pkg::DATA_W-1:0]       rsp_level,
   output logic                             rsp_switch_on,
   output logic                             rsp_changed,
   input  fts_pkg::cmd_type                 cmd,
   output fts_pkg::sts_type                 sts
);

   localparam int DW      = fts_pkg::DATA_W;
   localparam int LW      = fts_pkg::LEN_W;
   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W   = DW + $clog2(MAX_WINDOW);
   localparam int CNT_W   = $clog2(SUM_W);
   localparam int CMP_W   = (IDX_W + 1 > LW) ? IDX_W + 1 : LW;
   localparam int MaxLenI = (MAX_WINDOW < (2 ** LW) - 1) ? MAX_WINDOW : (2 ** LW) - 1;
   localparam logic [LW-1:0]    MaxLen  = LW'(MaxLenI);
   localparam logic [CNT_W-1:0] LastCnt = CNT_W'(SUM_W - 1);
   localparam logic [SUM_W-1:0] SatLvl  = SUM_W'({DW{1'b1}});

   // configuration
   logic                            filter_en_ff;
   logic [LW-1:0]                   win_len_ff;
   logic [fts_pkg::MODE_W-1:0]      mode_ff;
   logic [DW-1:0]                   thr_single_ff, thr_low_ff, thr_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_en_ff  <= 1'b0;
         win_len_ff    <= LW'(1);
         mode_ff       <= fts_pkg::MODE_NONE;
         thr_single_ff <= '0;
         thr_low_ff    <= '0;
         thr_high_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fts_pkg::CSR_FILTER_ENABLE:    filter_en_ff  <= csr_wdata[0];
            fts_pkg::CSR_WINDOW_LENGTH:    win_len_ff    <= csr_wdata[LW-1:0];
            fts_pkg::CSR_EVENT_MODE:       mode_ff       <= csr_wdata[fts_pkg::MODE_W-1:0];
            fts_pkg::CSR_SINGLE_THRESHOLD: thr_single_ff <= csr_wdata[DW-1:0];
            fts_pkg::CSR_LOW_THRESHOLD:    thr_low_ff    <= csr_wdata[DW-1:0];
            fts_pkg::CSR_HIGH_THRESHOLD:   thr_high_ff   <= csr_wdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective window length: zero counts as one, capped at the store depth and at 31
   logic [LW-1:0] eff_len;
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = LW'(1);
      end else if (win_len_ff > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = win_len_ff;
      end
   end

   // ring position advance
   logic [IDX_W-1:0] ring_ff, ring_in;
   logic [CMP_W-1:0] pos_inc;
   logic [IDX_W-1:0] pos_next;

   assign pos_inc  = CMP_W'(ring_ff) + CMP_W'(1);
   assign pos_next = (pos_inc >= CMP_W'(eff_len)) ? '0 : pos_inc[IDX_W-1:0];

   logic [DW-1:0]    sample_ff;
   logic [MAX_WINDOW-1:0] vld_ff;
   logic             vld_rd_ff;
   logic [DW-1:0]    rd_data;
   logic [DW-1:0]    old_val;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_sub;

   fts_ram #(
      .WIDTH  (DW),
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (ring_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.mem_read),
      .rd_addr (pos_next),
      .rd_data (rd_data)
   );

   // never-written entries read as zero
   assign old_val = vld_rd_ff ? rd_data : '0;
   assign sum_sub = (sum_ff < SUM_W'(old_val)) ? '0 : sum_ff - SUM_W'(old_val);
   assign sum_in  = sum_sub + SUM_W'(sample_ff);
   assign ring_in = pos_next;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
      if (cmd.mem_read) begin
         vld_rd_ff <= vld_ff[pos_next];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '0;
         sum_ff  <= '0;
         vld_ff  <= '0;
      end else begin
         if (cmd.mem_read) begin
            ring_ff <= ring_in;
         end
         if (cmd.update) begin
            sum_ff          <= sum_in;
            vld_ff[ring_ff] <= 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [LW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LW:0]      trial;
   logic             q_bit;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign q_bit = (trial >= {1'b0, eff_len});

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.update) begin
         quo_in = sum_in;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[SUM_W-2:0], q_bit};
         rem_in = q_bit ? LW'(trial - {1'b0, eff_len}) : trial[LW-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // level and switch decision
   logic [DW-1:0] level;
   logic          next_on;
   logic          held_ff;

   always_comb begin
      if (!filter_en_ff) begin
         level = sample_ff;
      end else if (quo_ff > SatLvl) begin
         level = '1;
      end else begin
         level = quo_ff[DW-1:0];
      end
   end

   always_comb begin
      next_on = held_ff;
      case (mode_ff)
         fts_pkg::MODE_SINGLE: next_on = (level >= thr_single_ff);
         fts_pkg::MODE_HYST: begin
            if (level <= thr_low_ff) begin
               next_on = 1'b0;
            end else if (level >= thr_high_ff) begin
               next_on = 1'b1;
            end
         end
         default: next_on = held_ff;
      endcase
   end

   // result register
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_level_ff;
   logic          rsp_switch_on_ff, rsp_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
         held_ff      <= next_on;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_level_ff     <= level;
         rsp_switch_on_ff <= next_on;
         rsp_changed_ff   <= next_on ^ held_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_switch_on = rsp_switch_on_ff;
   assign rsp_changed   = rsp_changed_ff;

   assign sts.filter_en = filter_en_ff;
   assign sts.div_last  = (cnt_ff == LastCnt);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== design/filtered_threshold_switch.sv =====
// ----------------------------------------------------------------------------
// filtered_threshold_switch
// Moving-average filter with single or hysteresis threshold switch output.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------
//  request | req_sample                              | req_valid/ready
//  result  | rsp_level, rsp_switch_on, rsp_changed   | rsp_valid/ready
//  config  | csr_index, csr_wdata                    | csr_we
//
//  filtered item: window read, update, then a serial divide of the running sum
//  by the effective window length, one quotient bit per cycle.
//  raw item (filter off): straight to the result load. new items wait for idle.
//  reset is synchronous; the store uses per-entry valid bits, no clearing pass.
//  a waiting result stalls the next item only at its final load step.
// ----------------------------------------------------------------------------
module filtered_threshold_switch #(
   parameter int MAX_WINDOW = fts_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fts_pkg::DATA_W-1:0]       req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fts_pkg::DATA_W-1:0]       rsp_level,
   output logic                             rsp_switch_on,
   output logic                             rsp_changed
);

   fts_pkg::cmd_type cmd;
   fts_pkg::sts_type sts;

   fts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fts_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level     (rsp_level),
      .rsp_switch_on (rsp_switch_on),
      .rsp_changed   (rsp_changed),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule
